@@ sv/msrg_pkg.sv @@
// Shared types and constants of the multi-axis step rate generator.
`default_nettype none

package msrg_pkg;

  // Number of axes served, one lane each.
  localparam int NUM_AXES = 4;

  // Fixed field widths.
  localparam int MASK_W = 4;
  localparam int RATE_W = 20;
  localparam int ACC_W  = 21;
  localparam int SUM_W  = 22;
  localparam int AXIS_W = 2;

  localparam logic [RATE_W-1:0] TICK_FREQ_RESET = RATE_W'(25000);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ATTACH   = 2'd1,
    OP_DETACH   = 2'd2,
    OP_SET_RATE = 2'd3
  } op_t;

  // Command broadcast to every lane for one accepted item.
  typedef struct packed {
    logic              fire;
    op_t               op;
    logic [RATE_W-1:0] tick_frequency;
    logic [RATE_W-1:0] rate_clamped;
    logic              forward;
  } lane_cmd_t;

  // What one lane reports for the item being accepted.
  typedef struct packed {
    logic step;
    logic finished;
    logic attached;
    logic direction;
  } lane_stat_t;

  // One result item.
  typedef struct packed {
    logic [MASK_W-1:0] step_mask;
    logic [MASK_W-1:0] direction_mask;
    logic [MASK_W-1:0] attached_mask;
    logic [MASK_W-1:0] finished_mask;
  } result_t;

endpackage

`default_nettype wire

@@ sv/msrg_lane.sv @@
// One axis lane: phase accumulator, rate, attach and direction state.
`default_nettype none

module msrg_lane (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msrg_pkg::lane_cmd_t  cmd,
  input  wire logic                 hit,
  input  wire logic                 keep_going,
  output msrg_pkg::lane_stat_t      stat
);
  import msrg_pkg::*;

  logic [ACC_W-1:0]  acc, acc_next;
  logic [RATE_W-1:0] rate, rate_next;
  logic              attached, attached_next;
  logic              direction, direction_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  wrapped;
  logic              step;
  logic              finished;

  assign sum     = SUM_W'(acc) + SUM_W'(rate);
  assign wrapped = sum - SUM_W'(cmd.tick_frequency);

  always_comb begin
    acc_next       = acc;
    rate_next      = rate;
    attached_next  = attached;
    direction_next = direction;
    step           = 1'b0;
    finished       = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        if (attached && (rate != '0)) begin
          if (sum >= SUM_W'(cmd.tick_frequency)) begin
            step = 1'b1;
            if (!keep_going) begin
              rate_next = '0;
              acc_next  = '0;
              finished  = 1'b1;
            end else begin
              acc_next = wrapped[ACC_W-1:0];
            end
          end else begin
            acc_next = sum[ACC_W-1:0];
          end
        end
      end
      OP_ATTACH: begin
        if (hit) begin
          acc_next       = '0;
          rate_next      = '0;
          direction_next = 1'b0;
          attached_next  = 1'b1;
        end
      end
      OP_DETACH: begin
        if (hit) begin
          rate_next     = '0;
          attached_next = 1'b0;
        end
      end
      OP_SET_RATE: begin
        if (hit && attached) begin
          direction_next = cmd.forward;
          rate_next      = cmd.rate_clamped;
          if (cmd.rate_clamped == '0) begin
            acc_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      rate      <= '0;
      attached  <= 1'b0;
      direction <= 1'b0;
    end else if (cmd.fire) begin
      acc       <= acc_next;
      rate      <= rate_next;
      attached  <= attached_next;
      direction <= direction_next;
    end
  end

  assign stat.step      = step;
  assign stat.finished  = finished;
  assign stat.attached  = attached_next;
  assign stat.direction = direction_next;

endmodule

`default_nettype wire

@@ sv/msrg_merge.sv @@
// Merges the lane reports into result masks and buffers them for output.
`default_nettype none

module msrg_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  input  wire msrg_pkg::lane_stat_t [msrg_pkg::NUM_AXES-1:0] stat,
  output logic                                       space,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output msrg_pkg::result_t                          out_data
);
  import msrg_pkg::*;

  logic [NUM_AXES-1:0] step_v, fin_v, att_v, dir_v;
  result_t             merged;
  result_t             main_data, skid_data;
  logic                main_valid, skid_valid;
  logic                pop;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      step_v[i] = stat[i].step;
      fin_v[i]  = stat[i].finished;
      att_v[i]  = stat[i].attached;
      dir_v[i]  = stat[i].direction;
    end
  end

  // Axes beyond the mask width are dropped, missing ones read as zero.
  assign merged.step_mask      = MASK_W'({{MASK_W{1'b0}}, step_v});
  assign merged.direction_mask = MASK_W'({{MASK_W{1'b0}}, dir_v});
  assign merged.attached_mask  = MASK_W'({{MASK_W{1'b0}}, att_v});
  assign merged.finished_mask  = MASK_W'({{MASK_W{1'b0}}, fin_v});

  assign pop   = main_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= merged;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= merged;
      end else begin
        skid_data <= merged;
      end
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

`default_nettype wire

@@ sv/multi_axis_step_rate_generator.sv @@
// Top level of the four-axis phase-accumulator step rate generator.
`default_nettype none

// Drives up to four stepper axes from one shared tick. Each input transfer
// carries one operation: a tick, which adds every attached, running axis's
// rate to its phase accumulator and steps each axis whose sum reaches
// tick_frequency; attach, detach, or set rate for one axis. Every input
// transfer yields exactly one output transfer with the step and finished
// masks of that item and the direction and attached masks as they stand
// after it. The axes sit in parallel lanes, each holding its own
// accumulator, rate, direction and attached bit, and all lanes work on the
// same item in the same cycle; the merging stage gathers their bits into
// the masks and holds them in a two-entry output buffer. One item is taken
// every clock cycle while input ready is high; each result is registered in
// the output buffer before it is offered. Input ready depends only on the
// output buffer, so the block keeps accepting while one result waits to be
// taken and stalls only when two are waiting. The tick frequency register
// (reset 25000) is written through the configuration channel, which is
// always ready; it should only be changed while no item is in flight.
// Set-rate requests are clamped to half the tick frequency, rounded down.
module multi_axis_step_rate_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [msrg_pkg::RATE_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      operation,
  input  wire logic [msrg_pkg::AXIS_W-1:0]     axis,
  input  wire logic [msrg_pkg::RATE_W-1:0]     steps_per_second,
  input  wire logic                            forward,
  input  wire logic [msrg_pkg::MASK_W-1:0]     keep_going_mask,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [msrg_pkg::MASK_W-1:0]          step_mask,
  output logic [msrg_pkg::MASK_W-1:0]          direction_mask,
  output logic [msrg_pkg::MASK_W-1:0]          attached_mask,
  output logic [msrg_pkg::MASK_W-1:0]          finished_mask
);
  import msrg_pkg::*;

  logic [RATE_W-1:0]                  tick_frequency;
  logic [RATE_W-1:0]                  rate_cap;
  lane_cmd_t                          cmd;
  lane_stat_t [NUM_AXES-1:0]          stat;
  logic [NUM_AXES+MASK_W-1:0]         keep_wide;
  logic                               in_fire;
  logic                               space;
  result_t                            out_data;

  // The configuration register accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= TICK_FREQ_RESET;
    end else if (cfg_valid) begin
      tick_frequency <= cfg_data;
    end
  end

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  // The cap is half the threshold; one clamp is shared by all lanes.
  assign rate_cap = tick_frequency >> 1;

  assign cmd.fire           = in_fire;
  assign cmd.op             = op_t'(operation);
  assign cmd.tick_frequency = tick_frequency;
  assign cmd.rate_clamped   = (steps_per_second > rate_cap) ? rate_cap : steps_per_second;
  assign cmd.forward        = forward;

  // Lanes past the width of the keep-going mask see a clear bit.
  assign keep_wide = {{NUM_AXES{1'b0}}, keep_going_mask};

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    msrg_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .hit        (int'(axis) == g),
      .keep_going (keep_wide[g]),
      .stat       (stat[g])
    );
  end

  msrg_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .stat      (stat),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign step_mask      = out_data.step_mask;
  assign direction_mask = out_data.direction_mask;
  assign attached_mask  = out_data.attached_mask;
  assign finished_mask  = out_data.finished_mask;

  // An axis can only finish on a tick on which it also stepped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((finished_mask & ~step_mask) == '0))
    else $error("finished axis without a step");

  // A stepping axis is attached, and a tick does not change attachment.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((step_mask & ~attached_mask) == '0))
    else $error("step on a detached axis");

  // The input side only stalls while results are queued for output.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output buffer");

  // A configuration write lands in the threshold register.
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> tick_frequency == $past(cfg_data))
    else $error("tick frequency write lost");

endmodule

`default_nettype wire
